[hw/rtl/pte_pkg.sv]
package pte_pkg;

  // fixed-point constants
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] KINV_Q30    = 34'sd652032874;
  localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
  localparam logic [31:0]        RC_MAX      = 32'h8000_0000;

  // one item as it travels down the chain of cells
  typedef struct packed {
    logic                    pass;
    logic                    faster;
    logic                    ident;
    logic [3:0][31:0]        q_raw;
    logic [2:0][31:0]        t_raw;
    logic [31:0]             sig;
    logic [31:0]             prev;
    logic [31:0]             cur;
    logic                    wneg;
    logic [30:0]             wmag;
    logic [2:0]              vneg;
    logic [2:0][30:0]        vmag;
    logic [2:0][61:0]        sq;
    logic [63:0]             s_rem;
    logic [63:0]             s_res;
    logic [32:0]             d_rem;
    logic [61:0]             rq;
    logic signed [33:0]      cx;
    logic signed [33:0]      cy;
    logic signed [33:0]      cz;
    logic [30:0]             h;
    logic [31:0]             rc;
    logic [62:0]             hprod;
    logic [31:0]             hs;
    logic [2:0][63:0]        tprod;
    logic [2:0][31:0]        tout;
    logic [61:0]             lx;
    logic [32:0]             lg;
    logic [64:0]             lnprod;
    logic [31:0]             ln;
    logic [63:0]             tp;
    logic [31:0]             thr;
    logic [30:0]             sinv;
    logic [31:0]             qw_out;
    logic [2:0][61:0]        num;
    logic [2:0][31:0]        frem;
    logic [2:0][30:0]        fq;
    logic [3:0][31:0]        o_q;
    logic [2:0][31:0]        o_t;
    logic [31:0]             o_thr;
    logic                    o_pass;
  } pte_item_t;

  // cell where the divider, square root and vectoring branches meet
  function automatic int pte_join_stage(input int steps);
    return (((34 + steps) > 61) ? (34 + steps) : 61) + 1;
  endfunction

  // last cell of the chain
  function automatic int pte_last_stage(input int steps);
    return pte_join_stage(steps) + 36 + steps;
  endfunction

  // floor(atan(2^-i) * 2^30)
  function automatic logic signed [33:0] pte_atan(input int i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      0: r = 34'sd843314856;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525158;
      4: r = 34'sd67021686;
      5: r = 34'sd33543515;
      6: r = 34'sd16775850;
      7: r = 34'sd8388437;
      8: r = 34'sd4194282;
      9: r = 34'sd2097149;
      default: begin
        if (i < 31) begin
          r = (34'sd1 <<< (30 - i)) - 34'sd1;
        end else begin
          r = '0;
        end
      end
    endcase
    return r;
  endfunction

  // clamp to [-1.0, 1.0] in Q1.30
  function automatic logic signed [31:0] pte_clampq(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sd1073741824;
    end else if (v < -ONE_Q30) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // magnitude of a clamped quaternion part
  function automatic logic [30:0] pte_mag31(input logic signed [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    return m[30:0];
  endfunction

endpackage

[hw/rtl/pose_time_extrapolator.sv]
// channel | handshake            | payload
// in      | in_valid / in_ready   | in_qw..in_qz, in_tx..in_tz, previous_interval,
//         |                      | current_interval, in_threshold
// out     | out_valid / out_ready| out_qw..out_qz, out_tx..out_tz, out_threshold,
//         |                      | passed_through
//
// one request enters per cycle unless the chain is held; each passes through the whole chain,
// which contains the 62-bit ratio divider, the 32-step root, the vectoring and rotation cordic,
// log squaring and the 31-bit axis divider
// the last cell of the chain is the output register
// when a result waits and out_ready is low the whole chain holds
// rst is synchronous and clears the valid bit of every cell
module pose_time_extrapolator
  import pte_pkg::*;
#(
  parameter int CORDIC_STEPS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_qw,
  input  logic [31:0] in_qx,
  input  logic [31:0] in_qy,
  input  logic [31:0] in_qz,
  input  logic [31:0] in_tx,
  input  logic [31:0] in_ty,
  input  logic [31:0] in_tz,
  input  logic [31:0] previous_interval,
  input  logic [31:0] current_interval,
  input  logic [31:0] in_threshold,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_qw,
  output logic [31:0] out_qx,
  output logic [31:0] out_qy,
  output logic [31:0] out_qz,
  output logic [31:0] out_tx,
  output logic [31:0] out_ty,
  output logic [31:0] out_tz,
  output logic [31:0] out_threshold,
  output logic        passed_through
);

  localparam int NUM_CELLS = pte_last_stage(CORDIC_STEPS) + 1;

  logic                 adv;
  logic [NUM_CELLS:0]   vld;
  pte_item_t            item [NUM_CELLS+1];
  pte_item_t            head;

  // chain moves whenever the output register is free or being emptied
  assign adv      = !vld[NUM_CELLS] || out_ready;
  assign in_ready = adv;

  // request enters the chain with all working fields cleared
  always_comb begin
    head          = '0;
    head.q_raw[0] = in_qw;
    head.q_raw[1] = in_qx;
    head.q_raw[2] = in_qy;
    head.q_raw[3] = in_qz;
    head.t_raw[0] = in_tx;
    head.t_raw[1] = in_ty;
    head.t_raw[2] = in_tz;
    head.prev     = previous_interval;
    head.cur      = current_interval;
    head.sig      = in_threshold;
  end

  assign vld[0]  = in_valid;
  assign item[0] = head;

  // chain of cells
  for (genvar s = 0; s < NUM_CELLS; s++) begin : g_cell
    pte_cell #(
      .STAGE (s),
      .STEPS (CORDIC_STEPS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (vld[s]),
      .in_item  (item[s]),
      .out_vld  (vld[s+1]),
      .out_item (item[s+1])
    );
  end

  // result ports from the last cell
  assign out_valid      = vld[NUM_CELLS];
  assign out_qw         = item[NUM_CELLS].o_q[0];
  assign out_qx         = item[NUM_CELLS].o_q[1];
  assign out_qy         = item[NUM_CELLS].o_q[2];
  assign out_qz         = item[NUM_CELLS].o_q[3];
  assign out_tx         = item[NUM_CELLS].o_t[0];
  assign out_ty         = item[NUM_CELLS].o_t[1];
  assign out_tz         = item[NUM_CELLS].o_t[2];
  assign out_threshold  = item[NUM_CELLS].o_thr;
  assign passed_through = item[NUM_CELLS].o_pass;

  // chain is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a held chain keeps every valid bit
  a_hold_chain: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld[NUM_CELLS:1]))
    else $error("chain moved while stalled");

  // extrapolated scalar part stays inside the unit range
  a_qw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !passed_through |->
      ($signed(out_qw) <= 32'sd1073741824) && ($signed(out_qw) >= -32'sd1073741824))
    else $error("scalar part out of range");

endmodule

[hw/rtl/pte_cell.sv]
module pte_cell
  import pte_pkg::*;
#(
  parameter int STAGE = 0,
  parameter int STEPS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_vld,
  input  pte_item_t in_item,
  output logic      out_vld,
  output pte_item_t out_item
);

  localparam int JOIN     = pte_join_stage(STEPS);
  localparam bit DIV_ON   = (STAGE <= 61);
  localparam int DIV_BIT  = DIV_ON ? (61 - STAGE) : 0;
  localparam bit DIV_CUR  = (DIV_BIT >= 30);
  localparam int CUR_BIT  = DIV_CUR ? (DIV_BIT - 30) : 0;
  localparam bit SQRT_ON  = (STAGE >= 3) && (STAGE <= 34);
  localparam int SQRT_K   = SQRT_ON ? (STAGE - 3) : 0;
  localparam bit VEC_ON   = (STAGE >= 35) && (STAGE <= 34 + STEPS);
  localparam int VEC_K    = VEC_ON ? (STAGE - 35) : 0;
  localparam bit NORM_ON  = (STAGE >= JOIN) && (STAGE <= JOIN + 4);
  localparam int NORM_K   = NORM_ON ? (STAGE - JOIN) : 0;
  localparam int NORM_SH  = 16 >> NORM_K;
  localparam bit LSQ_ON   = (STAGE >= JOIN + 5) && (STAGE <= JOIN + 31);
  localparam int LSQ_BIT  = LSQ_ON ? (26 - (STAGE - JOIN - 5)) : 0;
  localparam bit ROT_ON   = (STAGE >= JOIN + 3) && (STAGE <= JOIN + 2 + STEPS);
  localparam int ROT_K    = ROT_ON ? (STAGE - JOIN - 3) : 0;
  localparam int SINC     = JOIN + 3 + STEPS;
  localparam int NUMC     = SINC + 1;
  localparam bit FDIV_ON  = (STAGE >= NUMC + 1) && (STAGE <= NUMC + 31);
  localparam int FDIV_K   = FDIV_ON ? (STAGE - NUMC - 1) : 0;
  localparam int FDIV_BIT = 30 - FDIV_K;
  localparam int FIN      = NUMC + 32;

  pte_item_t nxt;

  // step of whichever units live at this position of the chain
  always_comb begin
    logic [32:0]        dt;
    logic [63:0]        sb;
    logic [63:0]        sv;
    logic [63:0]        sr;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [33:0] nx;
    logic signed [33:0] at;
    logic [61:0]        nv;
    logic [61:0]        lp;
    logic [31:0]        lv;
    logic [64:0]        lr;
    logic [37:0]        ts;
    logic [63:0]        hr;
    logic [63:0]        tr;
    logic [33:0]        tq;
    logic [31:0]        ft;
    logic [31:0]        fr;
    logic signed [33:0] fs;
    logic [30:0]        nn;
    nxt = in_item;
    dt = '0; sb = '0; sv = '0; sr = '0;
    x = '0; y = '0; z = '0; nx = '0; at = '0;
    nv = '0; lp = '0; lv = '0; lr = '0; ts = '0; hr = '0; tr = '0; tq = '0;
    ft = '0; fr = '0; fs = '0;
    nn = in_item.s_res[30:0];

    // clamp quaternion, split sign and magnitude, flag special cases
    if (STAGE == 0) begin
      nxt.wneg = in_item.q_raw[0][31];
      nxt.wmag = pte_mag31(pte_clampq(34'(signed'(in_item.q_raw[0]))));
      for (int j = 0; j < 3; j++) begin
        nxt.vneg[j] = in_item.q_raw[j+1][31];
        nxt.vmag[j] = pte_mag31(pte_clampq(34'(signed'(in_item.q_raw[j+1]))));
      end
      nxt.pass   = (in_item.prev == '0) || (in_item.cur == '0);
      nxt.faster = in_item.cur > in_item.prev;
    end

    // ratio divider, one quotient bit per cell
    if (DIV_ON) begin
      dt = {in_item.d_rem[31:0], (DIV_CUR ? in_item.cur[CUR_BIT] : 1'b0)};
      if (dt >= {1'b0, in_item.prev}) begin
        dt = dt - {1'b0, in_item.prev};
        nxt.rq[DIV_BIT] = 1'b1;
      end
      nxt.d_rem = dt;
    end

    // squares of the vector part
    if (STAGE == 1) begin
      for (int j = 0; j < 3; j++) begin
        nxt.sq[j] = 62'(in_item.vmag[j]) * 62'(in_item.vmag[j]);
      end
    end

    // sum of squares, start of root
    if (STAGE == 2) begin
      nxt.s_rem = 64'(in_item.sq[0]) + 64'(in_item.sq[1]) + 64'(in_item.sq[2]);
      nxt.s_res = '0;
    end

    // integer square root, two radicand bits per cell
    if (SQRT_ON) begin
      sb = 64'd1 << (62 - 2 * SQRT_K);
      sv = in_item.s_rem;
      sr = in_item.s_res;
      if (sv >= sr + sb) begin
        sv = sv - (sr + sb);
        sr = (sr >> 1) + sb;
      end else begin
        sr = sr >> 1;
      end
      nxt.s_rem = sv;
      nxt.s_res = sr;
    end

    // vectoring cordic for the half angle
    if (VEC_ON) begin
      if (VEC_K == 0) begin
        x = 34'(in_item.wmag);
        y = 34'(nn);
        z = '0;
      end else begin
        x = in_item.cx;
        y = in_item.cy;
        z = in_item.cz;
      end
      at = pte_atan(VEC_K);
      if (y > 0) begin
        nx = x + (y >>> VEC_K);
        y  = y - (x >>> VEC_K);
        z  = z + at;
      end else begin
        nx = x - (y >>> VEC_K);
        y  = y + (x >>> VEC_K);
        z  = z - at;
      end
      nxt.cx = nx;
      nxt.cy = y;
      nxt.cz = z;
    end

    // join: clamp half angle, clamp ratio, zero axis
    if (STAGE == JOIN) begin
      if (in_item.cz < 0) begin
        nxt.h = '0;
      end else if (in_item.cz > HALF_PI_Q30) begin
        nxt.h = HALF_PI_Q30[30:0];
      end else begin
        nxt.h = in_item.cz[30:0];
      end
      nxt.rc    = (in_item.rq > 62'(RC_MAX)) ? RC_MAX : in_item.rq[31:0];
      nxt.ident = (nn == '0);
    end

    // log normalise, one shift size per cell
    if (NORM_ON) begin
      nv = (NORM_K == 0) ? in_item.rq : in_item.lx;
      if (nv >= (62'd1 << (30 + NORM_SH))) begin
        nv = nv >> NORM_SH;
        nxt.lg = in_item.lg + (33'(NORM_SH) << 27);
      end
      nxt.lx = nv;
    end

    // log2 fraction by squaring, one bit per cell
    if (LSQ_ON) begin
      lp = 62'(in_item.lx[30:0]) * 62'(in_item.lx[30:0]);
      lv = lp[61:30];
      if (lv[31]) begin
        lv = lv >> 1;
        nxt.lg[LSQ_BIT] = 1'b1;
      end
      nxt.lx = 62'(lv);
    end

    // ln = log2 * ln2
    if (STAGE == JOIN + 32) begin
      nxt.lnprod = 65'(in_item.lg) * 65'(LN2_Q32);
    end
    if (STAGE == JOIN + 33) begin
      lr = in_item.lnprod + 65'(33'h0_8000_0000);
      nxt.ln = lr[63:32];
    end
    if (STAGE == JOIN + 34) begin
      nxt.tp = 64'(in_item.sig) * 64'(in_item.ln);
    end

    // threshold raised only when the current interval is longer, saturating
    if (STAGE == JOIN + 35) begin
      ts = 38'(in_item.sig) + 38'(in_item.tp[63:27]);
      if (!in_item.faster) begin
        nxt.thr = in_item.sig;
      end else if (ts > 38'(32'hFFFF_FFFF)) begin
        nxt.thr = 32'hFFFF_FFFF;
      end else begin
        nxt.thr = ts[31:0];
      end
    end

    // angle and translation products
    if (STAGE == JOIN + 1) begin
      nxt.hprod = 63'(in_item.h) * 63'(in_item.rc);
      for (int j = 0; j < 3; j++) begin
        ft = in_item.t_raw[j][31] ? (32'd0 - in_item.t_raw[j]) : in_item.t_raw[j];
        nxt.tprod[j] = 64'(ft) * 64'(in_item.rc);
      end
    end

    // rounding of scaled angle and translation
    if (STAGE == JOIN + 2) begin
      hr = 64'(in_item.hprod) + 64'd536870912;
      nxt.hs = hr[61:30];
      if (hr[61:30] == '0) begin
        nxt.ident = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
        tr = in_item.tprod[j] + 64'd536870912;
        tq = tr[63:30];
        if (in_item.t_raw[j][31]) begin
          nxt.tout[j] = (tq > 34'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - tq[31:0]);
        end else begin
          nxt.tout[j] = (tq > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : tq[31:0];
        end
      end
    end

    // rotation cordic on pi/2 - h'
    if (ROT_ON) begin
      if (ROT_K == 0) begin
        x = KINV_Q30;
        y = '0;
        z = HALF_PI_Q30 - 34'(in_item.hs);
      end else begin
        x = in_item.cx;
        y = in_item.cy;
        z = in_item.cz;
      end
      at = pte_atan(ROT_K);
      if (z >= 0) begin
        nx = x - (y >>> ROT_K);
        y  = y + (x >>> ROT_K);
        z  = z - at;
      end else begin
        nx = x + (y >>> ROT_K);
        y  = y - (x >>> ROT_K);
        z  = z + at;
      end
      nxt.cx = nx;
      nxt.cy = y;
      nxt.cz = z;
    end

    // sine and cosine of the scaled half angle
    if (STAGE == SINC) begin
      x = (in_item.cx < 0) ? 34'sd0 : in_item.cx;
      fr = pte_clampq(x);
      nxt.sinv   = fr[30:0];
      nxt.qw_out = pte_clampq(in_item.cy);
    end

    // axis numerators with half-divisor rounding
    if (STAGE == NUMC) begin
      for (int j = 0; j < 3; j++) begin
        nxt.num[j] = 62'(in_item.vmag[j]) * 62'(in_item.sinv) + 62'(nn[30:1]);
      end
    end

    // axis divide by |v|, one quotient bit per cell in each lane
    if (FDIV_ON) begin
      for (int j = 0; j < 3; j++) begin
        fr = (FDIV_K == 0) ? {1'b0, in_item.num[j][61:31]} : in_item.frem[j];
        ft = {fr[30:0], in_item.num[j][FDIV_BIT]};
        if (ft >= {1'b0, nn}) begin
          ft = ft - {1'b0, nn};
          nxt.fq[j][FDIV_BIT] = 1'b1;
        end
        nxt.frem[j] = ft;
      end
    end

    // result selection
    if (STAGE == FIN) begin
      nxt.o_pass = in_item.pass;
      if (in_item.pass) begin
        nxt.o_q   = in_item.q_raw;
        nxt.o_t   = in_item.t_raw;
        nxt.o_thr = in_item.sig;
      end else begin
        nxt.o_t   = in_item.tout;
        nxt.o_thr = in_item.thr;
        if (in_item.ident) begin
          nxt.o_q[0] = 32'd1073741824;
          nxt.o_q[1] = '0;
          nxt.o_q[2] = '0;
          nxt.o_q[3] = '0;
        end else begin
          nxt.o_q[0] = in_item.qw_out;
          for (int j = 0; j < 3; j++) begin
            fs = 34'(in_item.fq[j]);
            if (in_item.vneg[j] != in_item.wneg) begin
              fs = -fs;
            end
            nxt.o_q[j+1] = pte_clampq(fs);
          end
        end
      end
    end
  end

  // valid bit of this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  // payload of this cell
  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= nxt;
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import pte_pkg::*;

  localparam int CORDIC_STEPS = 32;
  localparam int LATENCY = 140;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam longint ONE = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint KINV = 64'sd652032874;
  localparam longint unsigned LN2 = 64'd2977044472;

  typedef struct packed {
    logic [31:0] qw, qx, qy, qz, tx, ty, tz, thr;
    logic pass;
  } pose_result_t;

  typedef struct {
    logic [31:0] qw, qx, qy, qz, tx, ty, tz, prev, cur, thr;
  } pose_request_t;

  // predicted pose outcomes, checked in order
  class pose_scoreboard;
    pose_result_t pending[$];
    int errors;

    function automatic longint atan_entry(int i);
      longint t [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149};
      if (i < 10) return t[i];
      if (i < 31) return (64'sd1 <<< (30 - i)) - 1;
      return 0;
    endfunction

    function automatic longint shr(longint v, int s);
      return v >>> s;
    endfunction

    function automatic longint clamp1(longint v);
      if (v > ONE) return ONE;
      if (v < -ONE) return -ONE;
      return v;
    endfunction

    function automatic longint unsigned absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    // natural log of a ratio >= 1 in Q.27
    function automatic longint unsigned log_ratio(longint unsigned rq);
      int m;
      longint unsigned x, lg;
      logic [127:0] p;
      m = 63;
      while (m > 0 && !rq[m]) m--;
      if (m < 30) return 0;
      x = rq >> (m - 30);
      lg = longint'(m - 30) << 27;
      for (int i = 26; i >= 0; i--) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x >>= 1;
          lg |= 64'd1 << i;
        end
      end
      p = 128'(lg) * LN2 + (128'd1 << 31);
      return p[95:32];
    endfunction

    function automatic logic [31:0] stretch(logic [31:0] tr, longint unsigned rc);
      longint t;
      longint unsigned q;
      t = longint'($signed(tr));
      q = (absval(t) * rc + (64'd1 << 29)) >> 30;
      if (t < 0) return q > 64'd2147483648 ? 32'h8000_0000 : 32'(-longint'(q));
      return q > 64'd2147483647 ? 32'h7FFF_FFFF : 32'(q);
    endfunction

    function automatic void turn(pose_request_t rq, longint unsigned rc,
                                 ref pose_result_t r);
      longint w, x, y, z, nx, s;
      longint v [3];
      longint unsigned n, hs, q;
      w = clamp1(longint'($signed(rq.qw)));
      v[0] = clamp1(longint'($signed(rq.qx)));
      v[1] = clamp1(longint'($signed(rq.qy)));
      v[2] = clamp1(longint'($signed(rq.qz)));
      n = root(absval(v[0]) ** 2 + absval(v[1]) ** 2 + absval(v[2]) ** 2);
      r.qw = 32'h4000_0000;
      r.qx = 0;
      r.qy = 0;
      r.qz = 0;
      if (n == 0) return;
      // vectoring for half angle
      x = absval(w);
      y = n;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (y > 0) begin
          nx = x + shr(y, i); y = y - shr(x, i); z += atan_entry(i);
        end else begin
          nx = x - shr(y, i); y = y + shr(x, i); z -= atan_entry(i);
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > HALF_PI) z = HALF_PI;
      hs = (longint'(z) * rc + (64'd1 << 29)) >> 30;
      if (hs == 0) return;
      // rotation for sin and cos of the scaled half angle
      z = HALF_PI - longint'(hs);
      x = KINV;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - shr(y, i); y = y + shr(x, i); z -= atan_entry(i);
        end else begin
          nx = x + shr(y, i); y = y - shr(x, i); z += atan_entry(i);
        end
        x = nx;
      end
      if (x < 0) x = 0;
      x = clamp1(x);
      r.qw = 32'(clamp1(y));
      for (int j = 0; j < 3; j++) begin
        q = (absval(v[j]) * longint'(x) + n / 2) / n;
        s = ((v[j] < 0) != (w < 0)) ? -longint'(q) : longint'(q);
        case (j)
          0: r.qx = 32'(clamp1(s));
          1: r.qy = 32'(clamp1(s));
          default: r.qz = 32'(clamp1(s));
        endcase
      end
    endfunction

    function void note_request(pose_request_t rq);
      pose_result_t r;
      longint unsigned pv, cv, sg, ratio, rc, sum;
      pv = rq.prev;
      cv = rq.cur;
      sg = rq.thr;
      if (pv == 0 || cv == 0) begin
        r = '{rq.qw, rq.qx, rq.qy, rq.qz, rq.tx, rq.ty, rq.tz, rq.thr, 1'b1};
      end else begin
        ratio = (cv << 30) / pv;
        r.thr = rq.thr;
        if (cv > pv) begin
          sum = sg + ((sg * log_ratio(ratio)) >> 27);
          r.thr = sum > M32 ? 32'hFFFF_FFFF : 32'(sum);
        end
        rc = ratio > (64'd2 << 30) ? (64'd2 << 30) : ratio;
        turn(rq, rc, r);
        r.tx = stretch(rq.tx, rc);
        r.ty = stretch(rq.ty, rc);
        r.tz = stretch(rq.tz, rc);
        r.pass = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(pose_result_t got);
      pose_result_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result qw=%h", got.qw);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp q=%h %h %h %h t=%h %h %h thr=%h p=%b / %s",
                   e.qw, e.qx, e.qy, e.qz, e.tx, e.ty, e.tz, e.thr, e.pass,
                   $sformatf("got q=%h %h %h %h t=%h %h %h thr=%h p=%b",
                             got.qw, got.qx, got.qy, got.qz, got.tx, got.ty,
                             got.tz, got.thr, got.pass));
      end
    endfunction
  endclass

  logic clk, rst, in_valid, in_ready, out_valid, out_ready, passed_through;
  logic [31:0] in_qw, in_qx, in_qy, in_qz, in_tx, in_ty, in_tz;
  logic [31:0] previous_interval, current_interval, in_threshold;
  logic [31:0] out_qw, out_qx, out_qy, out_qz, out_tx, out_ty, out_tz, out_threshold;

  pose_scoreboard board;
  bit calm;
  bit hold_sink;

  pose_time_extrapolator #(.CORDIC_STEPS(CORDIC_STEPS)) u_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  // drive one request and wait for its acceptance
  task automatic send_request(pose_request_t rq);
    if (!calm && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 9)) @(negedge clk);
    {in_qw, in_qx, in_qy, in_qz, in_tx, in_ty, in_tz} =
      {rq.qw, rq.qx, rq.qy, rq.qz, rq.tx, rq.ty, rq.tz};
    previous_interval = rq.prev;
    current_interval = rq.cur;
    in_threshold = rq.thr;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    board.note_request(rq);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h4000_0000;
      1: return 32'hC000_0000;
      2: return 0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
    endcase
  endfunction

  // mostly unit quaternions, sometimes raw or out of range
  function automatic pose_request_t random_request();
    pose_request_t rq;
    real a, ux, uy, uz, nn;
    a = ($urandom % 10000) / 10000.0 * 3.14159;
    ux = $urandom_range(0, 2000) - 1000.0;
    uy = $urandom_range(0, 2000) - 1000.0;
    uz = $urandom_range(0, 2000) - 1000.0;
    nn = $sqrt(ux * ux + uy * uy + uz * uz) + 1e-9;
    if ($urandom_range(0, 3) != 0) begin
      rq.qw = 32'($rtoi($cos(a / 2) * 1073741824.0));
      rq.qx = 32'($rtoi($sin(a / 2) * ux / nn * 1073741824.0));
      rq.qy = 32'($rtoi($sin(a / 2) * uy / nn * 1073741824.0));
      rq.qz = 32'($rtoi($sin(a / 2) * uz / nn * 1073741824.0));
      if ($urandom_range(0, 1)) rq.qw = -rq.qw;
    end else begin
      rq.qw = rand_q(); rq.qx = rand_q(); rq.qy = rand_q(); rq.qz = rand_q();
    end
    rq.tx = $urandom_range(0, 3) == 0 ? $urandom : 32'($signed($urandom_range(0, 2000000)) - 1000000);
    rq.ty = $urandom;
    rq.tz = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 400000));
    rq.prev = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(50000, 150000);
    rq.cur = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(30000, 300000);
    if ($urandom_range(0, 19) == 0) rq.prev = 0;
    if ($urandom_range(0, 19) == 0) rq.cur = 0;
    rq.thr = $urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 200000);
    return rq;
  endfunction

  // result side with random stalls and one long hold-off
  initial begin
    pose_result_t got;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (hold_sink) out_ready = 0;
      else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready = !hold_sink;
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{out_qw, out_qx, out_qy, out_qz, out_tx, out_ty, out_tz,
                out_threshold, passed_through};
        board.check_result(got);
      end
      @(negedge clk);
    end
  end

  initial begin
    pose_request_t rq;
    int waited;
    board = new();
    rst = 1;
    in_valid = 0;
    calm = 0;
    hold_sink = 0;
    {in_qw, in_qx, in_qy, in_qz, in_tx, in_ty, in_tz} = '0;
    previous_interval = 0;
    current_interval = 0;
    in_threshold = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed corners
    send_request('{32'h4000_0000, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 5, 77});
    send_request('{32'hDEAD_BEEF, 1, 2, 3, 4, 5, 6, 100, 0, 32'hFFFF_FFFF});
    send_request('{32'h4000_0000, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   1, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_request('{0, 32'h4000_0000, 0, 0, 32'h0001_0000, 0, 0, 100, 100, 65536});
    send_request('{0, 0, 0, 32'hC000_0000, 32'hFFFF_0000, 0, 0, 100, 200, 65536});
    send_request('{32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0, 1000, 0, 0, 100, 150, 65536});
    send_request('{32'hD2BE_C333, 32'h2D41_3CCD, 0, 0, 1000, 0, 0, 100, 50, 65536});
    send_request('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   0, 0, 0, 3, 7, 0});
    send_request('{32'h4000_0000, 1, 0, 0, 5, 5, 5, 32'hFFFF_FFFF, 1, 65536});
    send_request('{32'h3FFF_FFFF, 0, 32'h0000_8000, 0, 1, 32'hFFFF_FFFF, 2, 7, 8, 1});
    send_request('{32'h4000_0000, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 123});

    // sender pause until drained
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_sink = 1;
        repeat (400) @(negedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 200; i++) send_request(random_request());
    join

    for (int i = 0; i < 400; i++) begin
      if (i == 300) calm = 1;
      send_request(random_request());
    end

    waited = 0;
    while (board.pending.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
